>>> design/lru_replacement_tracker_core_macros.svh
// Assertion macros used by the tracker core.
`ifndef LRU_REPLACEMENT_TRACKER_CORE_MACROS_SVH
`define LRU_REPLACEMENT_TRACKER_CORE_MACROS_SVH

// Check a condition at every rising clock edge outside reset.
`define LRT_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Check that a consequent holds in the cycle after an antecedent.
`define LRT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/lrt_pkg.sv
// Package with codes, widths and the cell control type of the LRU tracker.
`timescale 1ns / 1ps

package lrt_pkg;

	localparam int unsigned OP_W     = 2;
	localparam int unsigned KEY_W    = 16;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned COUNT_W  = 5;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_VICTIM = 2'd1,
		OP_ERASE  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_DONE = 2'd0,
		STATUS_MISS = 2'd1,
		STATUS_FULL = 2'd2
	} status_t;

	// Per-cell control from the row controller.
	typedef struct packed {
		logic in_range;  // slot is below the current count
		logic match_en;  // compare against the broadcast key
		logic shift_en;  // compaction happens this cycle
		logic load;      // this slot takes the broadcast key
	} cell_ctl_t;

endpackage

>>> design/lrt_if.sv
// Request and response channel interfaces of the LRU tracker.
`timescale 1ns / 1ps

interface lrt_req_if;
	logic                       valid;
	logic                       ready;
	logic [lrt_pkg::OP_W-1:0]   op;
	logic [lrt_pkg::KEY_W-1:0]  key;

	modport source (output valid, output op, output key, input ready);
	modport sink   (input valid, input op, input key, output ready);
endinterface

interface lrt_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [lrt_pkg::STATUS_W-1:0]  status;
	logic [lrt_pkg::KEY_W-1:0]     victim_key;
	logic [lrt_pkg::COUNT_W-1:0]   count;

	modport source (output valid, output status, output victim_key, output count, input ready);
	modport sink   (input valid, input status, input victim_key, input count, output ready);
endinterface

>>> design/lrt_cell.sv
// One slot of the recency row: holds a key, compares it and shifts toward slot 0.
`timescale 1ns / 1ps

module lrt_cell #(
	parameter int unsigned KW = 16
) (
	input  logic               clk,
	input  lrt_pkg::cell_ctl_t ctl,
	input  logic [KW-1:0]      key,
	input  logic [KW-1:0]      nbr_key,
	input  logic               shift_in,
	output logic               shift_out,
	output logic               hit,
	output logic [KW-1:0]      key_q
);

	assign hit       = ctl.in_range && ctl.match_en && (key_q == key);
	// Once a slot at or below this one is removed, every higher slot moves down.
	assign shift_out = shift_in || hit;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			key_q <= key;
		end else if (ctl.shift_en && shift_out) begin
			key_q <= nbr_key;
		end
	end

endmodule

>>> design/lru_replacement_tracker_core.sv
// Top level of the LRU tracker: row of key cells, count and response register.
`timescale 1ns / 1ps
// A response beat appears in the cycle after its request beat is taken.
// One request per cycle while the response register is empty or draining; all cells compare and shift together.
// The critical path is the key compare plus the removal chain through the row.
// Reset clears the count and the response valid; cell keys are not reset
// and are only read below the count.

`include "lru_replacement_tracker_core_macros.svh"

module lru_replacement_tracker_core #(
	parameter int unsigned CAPACITY = 16,
	parameter int unsigned KEY_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	lrt_req_if.sink   req,
	lrt_rsp_if.source rsp
);

	// Stored key width: input keys carry only KEY_W bits.
	localparam int unsigned KW    = (KEY_BITS < lrt_pkg::KEY_W) ? KEY_BITS : lrt_pkg::KEY_W;
	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	logic [CNT_W-1:0] load_idx;

	logic                      rsp_valid_q;
	lrt_pkg::status_t          status_q;
	logic [lrt_pkg::KEY_W-1:0] victim_q;
	logic [lrt_pkg::COUNT_W-1:0] count_out_q;

	logic          accept;
	logic [KW-1:0] key_in;
	lrt_pkg::op_t  op;
	logic          is_ins;
	logic          is_vic;
	logic          is_era;
	logic          empty;
	logic          full;
	logic          any_hit;
	logic          pop;
	logic          remove;
	logic          append;
	logic          load_en;
	lrt_pkg::status_t status_d;

	logic [KW-1:0]       cell_key [CAPACITY];
	logic [CAPACITY-1:0] hit_vec;
	logic [CAPACITY:0]   shift_chain;

	// Take a new request whenever the response register is empty or draining.
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	assign op     = lrt_pkg::op_t'(req.op);
	assign key_in = req.key[KW-1:0];
	assign is_ins = (op == lrt_pkg::OP_INSERT);
	assign is_vic = (op == lrt_pkg::OP_VICTIM);
	assign is_era = (op == lrt_pkg::OP_ERASE);
	assign empty  = (count_q == '0);
	assign full   = (count_q >= CNT_W'(CAPACITY));

	// Keys are distinct, so at most one cell matches.
	assign any_hit = |hit_vec;

	// Victim removes slot 0: seed the removal chain at the bottom of the row.
	assign pop    = is_vic && !empty;
	assign remove = ((is_ins || is_era) && any_hit) || pop;

	// Touch: the key moves to the highest occupied slot after compaction. New key: append.
	assign append   = is_ins && !any_hit && !full;
	assign load_en  = accept && is_ins && (any_hit || !full);
	assign load_idx = any_hit ? (count_q - CNT_W'(1)) : count_q;

	assign shift_chain[0] = pop;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		lrt_pkg::cell_ctl_t ctl;
		logic [KW-1:0]      nbr;

		assign ctl.in_range = (CNT_W'(i) < count_q);
		assign ctl.match_en = is_ins || is_era;
		assign ctl.shift_en = accept && remove;
		assign ctl.load     = load_en && (load_idx == CNT_W'(i));

		// The top cell pulls in nothing; that slot falls out of the count.
		if (i == CAPACITY - 1) begin : g_top
			assign nbr = '0;
		end else begin : g_mid
			assign nbr = cell_key[i+1];
		end

		lrt_cell #(
			.KW (KW)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.key       (key_in),
			.nbr_key   (nbr),
			.shift_in  (shift_chain[i]),
			.shift_out (shift_chain[i+1]),
			.hit       (hit_vec[i]),
			.key_q     (cell_key[i])
		);
	end

	// Count after the operation.
	always_comb begin
		count_d = count_q;
		if (append) begin
			count_d = count_q + CNT_W'(1);
		end else if (pop || (is_era && any_hit)) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	// Status of the operation; an unused op code answers done.
	always_comb begin
		status_d = lrt_pkg::STATUS_DONE;
		if (is_ins && !any_hit && full) begin
			status_d = lrt_pkg::STATUS_FULL;
		end else if ((is_vic && empty) || (is_era && !any_hit)) begin
			status_d = lrt_pkg::STATUS_MISS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Response payload: hold until the next request beat.
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q    <= status_d;
			victim_q    <= pop ? lrt_pkg::KEY_W'(cell_key[0]) : '0;
			count_out_q <= lrt_pkg::COUNT_W'(count_d);
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = status_q;
	assign rsp.victim_key = victim_q;
	assign rsp.count      = count_out_q;

	`LRT_ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(CAPACITY), "count above capacity")
	`LRT_ASSERT_ALWAYS(a_single_hit, $onehot0(hit_vec), "key tracked in more than one slot")
	`LRT_ASSERT_NEXT(a_full_hold, accept && is_ins && !any_hit && full,
		count_q == $past(count_q), "dropped insert changed the count")
	`LRT_ASSERT_NEXT(a_rsp_follows, accept, rsp_valid_q, "request beat left no response")

endmodule

>>> test/tb_lru_replacement_tracker_core.sv
// Self-checking testbench for the LRU replacement tracker core.
`timescale 1ns / 1ps

module tb_lru_replacement_tracker_core;

	// Size the block as the stock configuration: 16 slots of 16-bit keys.
	localparam int unsigned SLOTS        = 16;
	localparam int unsigned RANDOM_ITEMS = 925;
	localparam int unsigned POOL_DEPTH   = 24;
	// Hold the response side off for a long stretch once this many beats are in.
	localparam int unsigned HOLD_AT_BEAT = 400;
	localparam int unsigned LONG_HOLD    = 120;
	// Bound the final drain; the block needs far less than this.
	localparam int unsigned DRAIN_LIMIT  = 5000;

	// One answer beat as the block returns it.
	typedef struct packed {
		lrt_pkg::status_t             status;
		logic [lrt_pkg::KEY_W-1:0]    victim_key;
		logic [lrt_pkg::COUNT_W-1:0]  count;
	} lru_answer_t;

	// One row of the directed table. Rows with pinned set carry an answer that
	// is obvious from the op semantics; the others take it from the predictor.
	typedef struct {
		lrt_pkg::op_t               op;
		logic [lrt_pkg::KEY_W-1:0]  key;
		bit                         pinned;
		lru_answer_t                answer;
	} lru_row_t;

	logic clk;
	logic arst_n;

	lrt_req_if req_ch ();
	lrt_rsp_if rsp_ch ();

	lru_replacement_tracker_core #(
		.CAPACITY(SLOTS),
		.KEY_BITS(lrt_pkg::KEY_W)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Predictor state: tracked keys, least recent at the front.
	logic [lrt_pkg::KEY_W-1:0] recency_q[$];
	// Answers owed by the block, oldest first.
	lru_answer_t               pending_answers[$];
	int unsigned               mismatch_count = 0;
	int unsigned               answer_beats = 0;
	bit                        long_hold_done;

	// Directed table: extremes, every op, and each corner case.
	// Fill to capacity with one-hot keys so every key bit toggles on the way.
	lru_row_t directed_rows [25] = '{
		// Victim and erase on an empty set both miss; an unused op is a no-op.
		'{lrt_pkg::OP_VICTIM, 16'h0000, 1'b1, '{lrt_pkg::STATUS_MISS, 16'h0000, 5'd0}},
		'{lrt_pkg::OP_ERASE,  16'h1234, 1'b1, '{lrt_pkg::STATUS_MISS, 16'h0000, 5'd0}},
		'{lrt_pkg::OP_NONE,   16'hFFFF, 1'b1, '{lrt_pkg::STATUS_DONE, 16'h0000, 5'd0}},
		'{lrt_pkg::OP_INSERT, 16'h0000, 1'b1, '{lrt_pkg::STATUS_DONE, 16'h0000, 5'd1}},
		'{lrt_pkg::OP_INSERT, 16'hFFFF, 1'b1, '{lrt_pkg::STATUS_DONE, 16'h0000, 5'd2}},
		// Touch the lowest key: it moves to the most recent end.
		'{lrt_pkg::OP_INSERT, 16'h0000, 1'b0, '0},
		'{lrt_pkg::OP_INSERT, 16'h0001, 1'b0, '0},
		'{lrt_pkg::OP_INSERT, 16'h0002, 1'b0, '0},
		'{lrt_pkg::OP_INSERT, 16'h0004, 1'b0, '0},
		'{lrt_pkg::OP_INSERT, 16'h0008, 1'b0, '0},
		'{lrt_pkg::OP_INSERT, 16'h0010, 1'b0, '0},
		'{lrt_pkg::OP_INSERT, 16'h0020, 1'b0, '0},
		'{lrt_pkg::OP_INSERT, 16'h0040, 1'b0, '0},
		'{lrt_pkg::OP_INSERT, 16'h0080, 1'b0, '0},
		'{lrt_pkg::OP_INSERT, 16'h0100, 1'b0, '0},
		'{lrt_pkg::OP_INSERT, 16'h0200, 1'b0, '0},
		'{lrt_pkg::OP_INSERT, 16'h0400, 1'b0, '0},
		'{lrt_pkg::OP_INSERT, 16'h0800, 1'b0, '0},
		'{lrt_pkg::OP_INSERT, 16'h1000, 1'b0, '0},
		'{lrt_pkg::OP_INSERT, 16'h2000, 1'b0, '0},
		// Full: a new key is dropped, a tracked key is still touched.
		'{lrt_pkg::OP_INSERT, 16'h4000, 1'b1, '{lrt_pkg::STATUS_FULL, 16'h0000, 5'd16}},
		'{lrt_pkg::OP_INSERT, 16'hFFFF, 1'b0, '0},
		'{lrt_pkg::OP_ERASE,  16'h8000, 1'b1, '{lrt_pkg::STATUS_MISS, 16'h0000, 5'd16}},
		// Pop from a full set, then erase the most recent key.
		'{lrt_pkg::OP_VICTIM, 16'h5A5A, 1'b0, '0},
		'{lrt_pkg::OP_ERASE,  16'hFFFF, 1'b0, '0}
	};

	// Apply one request to the predictor and return the answer it owes.
	function automatic lru_answer_t apply_request(lrt_pkg::op_t op,
			logic [lrt_pkg::KEY_W-1:0] key);
		lru_answer_t a;
		int          hit;
		a.status     = lrt_pkg::STATUS_DONE;
		a.victim_key = '0;
		hit          = -1;
		foreach (recency_q[i]) begin
			if (hit < 0 && recency_q[i] == key) hit = i;
		end
		case (op)
			lrt_pkg::OP_INSERT: begin
				if (hit >= 0) begin
					recency_q.delete(hit);
					recency_q.push_back(key);
				end else if (recency_q.size() >= SLOTS) begin
					a.status = lrt_pkg::STATUS_FULL;
				end else begin
					recency_q.push_back(key);
				end
			end
			lrt_pkg::OP_VICTIM: begin
				if (recency_q.size() == 0) begin
					a.status = lrt_pkg::STATUS_MISS;
				end else begin
					a.victim_key = recency_q.pop_front();
				end
			end
			lrt_pkg::OP_ERASE: begin
				if (hit >= 0) begin
					recency_q.delete(hit);
				end else begin
					a.status = lrt_pkg::STATUS_MISS;
				end
			end
			default: begin
			end
		endcase
		a.count = lrt_pkg::COUNT_W'(recency_q.size());
		return a;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH beat %0d %s: got 0x%0h, expected 0x%0h",
			answer_beats, what, got, want);
		mismatch_count++;
	endtask

	// Offer one request beat after a gap and hold it until the block takes it.
	// Keep valid high across back-to-back beats: only lower it when a gap follows.
	task automatic offer_request(lrt_pkg::op_t op, logic [lrt_pkg::KEY_W-1:0] key,
			bit pinned, lru_answer_t pinned_answer, int unsigned gap);
		lru_answer_t predicted;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.op    <= op;
		req_ch.key   <= key;
		do @(posedge clk); while (!req_ch.ready);
		predicted = apply_request(op, key);
		pending_answers.push_back(pinned ? pinned_answer : predicted);
	endtask

	// Pause the request side until every owed answer has come back.
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (pending_answers.size() != 0) @(posedge clk);
	endtask

	// Compare a taken answer beat with the oldest owed answer, field by field.
	task automatic check_answer();
		lru_answer_t want;
		answer_beats++;
		if (pending_answers.size() == 0) begin
			report_mismatch("unexpected answer, status", 32'(rsp_ch.status), '0);
			return;
		end
		want = pending_answers.pop_front();
		if (rsp_ch.status !== want.status)
			report_mismatch("status", 32'(rsp_ch.status), 32'(want.status));
		if (rsp_ch.victim_key !== want.victim_key)
			report_mismatch("victim_key", 32'(rsp_ch.victim_key), 32'(want.victim_key));
		if (rsp_ch.count !== want.count)
			report_mismatch("count", 32'(rsp_ch.count), 32'(want.count));
	endtask

	// Free-running clock, 10 ns period.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hold reset from time zero, then release it at a rising edge.
	initial begin
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Request side: directed table first, then random phases.
	initial begin
		logic [lrt_pkg::KEY_W-1:0] key_pool [POOL_DEPTH];
		lrt_pkg::op_t              op;
		logic [lrt_pkg::KEY_W-1:0] key;
		int unsigned               sent;
		int unsigned               phase;
		int unsigned               span;
		int unsigned               insert_pct;
		int unsigned               len;
		int unsigned               roll;
		int unsigned               guard;
		bit                        calm;

		req_ch.valid <= 1'b0;
		req_ch.op    <= lrt_pkg::OP_NONE;
		req_ch.key   <= '0;
		sent  = 0;
		phase = 0;
		foreach (key_pool[i]) key_pool[i] = lrt_pkg::KEY_W'($urandom);

		wait (arst_n);
		@(posedge clk);

		// Walk the directed table.
		foreach (directed_rows[i]) begin
			offer_request(directed_rows[i].op, directed_rows[i].key, directed_rows[i].pinned,
				directed_rows[i].answer, $urandom_range(0, 11));
		end
		// Pause until the table has fully answered.
		wait_drained();

		// Random phases. Each phase draws a key pool, a mix that leans toward
		// filling, balancing or draining the set, and whether the sender idles.
		while (sent < RANDOM_ITEMS) begin
			span = $urandom_range(4, POOL_DEPTH);
			for (int i = 0; i < POOL_DEPTH; i++) begin
				// Keep about half the pool so tracked keys carry over.
				if ($urandom_range(0, 1) == 0) key_pool[i] = lrt_pkg::KEY_W'($urandom);
			end
			case ($urandom_range(0, 2))
				0: insert_pct = 85;
				1: insert_pct = 55;
				default: insert_pct = 25;
			endcase
			calm = ($urandom_range(0, 3) == 0);
			len  = $urandom_range(30, 70);
			for (int j = 0; j < len && sent < RANDOM_ITEMS; j++) begin
				roll = $urandom_range(0, 99);
				if (roll < 4) begin
					op = lrt_pkg::OP_NONE;
				end else if (roll < 4 + insert_pct * 96 / 100) begin
					op = lrt_pkg::OP_INSERT;
				end else if ($urandom_range(0, 2) == 0) begin
					op = lrt_pkg::OP_VICTIM;
				end else begin
					op = lrt_pkg::OP_ERASE;
				end
				// Mostly pool keys to hit tracked entries; now and then a wild key.
				if ($urandom_range(0, 19) == 0) begin
					key = lrt_pkg::KEY_W'($urandom);
				end else begin
					key = key_pool[$urandom_range(0, span - 1)];
				end
				offer_request(op, key, 1'b0, '0, calm ? 0 : $urandom_range(0, 11));
				sent++;
			end
			// Every fourth phase, stop and let the block answer everything.
			if (phase % 4 == 3) wait_drained();
			phase++;
		end
		req_ch.valid <= 1'b0;

		// Wait for the last answers, with a bound, then allow the pipeline to settle.
		guard = 0;
		while (pending_answers.size() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (4) @(posedge clk);
		if (pending_answers.size() != 0)
			report_mismatch("answers never returned", 32'(pending_answers.size()), '0);

		if (mismatch_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// Response side: random stalls per beat, calm stretches with no stall, and
	// one long hold-off, started while the sender is offering, that backs the
	// block up into its request side.
	initial begin
		int unsigned gap;
		int unsigned calm_left;
		rsp_ch.ready <= 1'b0;
		calm_left      = 0;
		long_hold_done = 1'b0;
		wait (arst_n);
		forever begin
			if (!long_hold_done && answer_beats >= HOLD_AT_BEAT && req_ch.valid) begin
				long_hold_done = 1'b1;
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			if (calm_left > 0) begin
				calm_left--;
				gap = 0;
			end else begin
				gap = $urandom_range(0, 11);
				if ($urandom_range(0, 29) == 0) calm_left = $urandom_range(20, 60);
			end
			if (gap > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			check_answer();
		end
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
